/* sv/chtsd_pkg.sv */
// ============================================================================
// chtsd_pkg
// Shared types and constants of the convex hull trick segmentation DP core.
// ============================================================================
package chtsd_pkg;

    localparam int LEN_FIELD_W = 16;
    localparam int LIMIT_W     = 26;
    localparam int COST_W      = 62;
    localparam int WORD_W      = 64;
    localparam int MUL_W       = 32;

    localparam logic [WORD_W-1:0] COST_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

    // One queued item: already masked length and the new-sequence flag.
    typedef struct packed {
        logic                   first;
        logic [LEN_FIELD_W-1:0] len;
    } item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_KEY,
        ST_F_RDP,
        ST_F_LATP,
        ST_F_LATQ,
        ST_F_MUL,
        ST_F_CMP,
        ST_EV_MAG,
        ST_EV_COST,
        ST_EV_SQ,
        ST_EV_Y,
        ST_B_CHK,
        ST_B_LATR,
        ST_B_LATL,
        ST_B_M0,
        ST_B_M1,
        ST_B_M2,
        ST_B_M3,
        ST_B_SUM,
        ST_B_CMP,
        ST_PUSH,
        ST_OUT
    } state_t;

endpackage

/* sv/chtsd_front.sv */
// ============================================================================
// chtsd_front
// Accepts input items, masks the length and holds them in a two-entry queue.
// ============================================================================
module chtsd_front #(
    parameter int LEN_W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output chtsd_pkg::item_t     q_item
);
    import chtsd_pkg::*;

    localparam logic [LEN_FIELD_W-1:0] LEN_MASK =
        LEN_FIELD_W'((17'd1 << LEN_W) - 17'd1);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    item_t      in_item;

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        in_item.first = s_tuser;
        in_item.len   = s_tdata & LEN_MASK;
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next     = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* sv/chtsd_back.sv */
// ============================================================================
// chtsd_back
// Sequencer that runs the hull queue: front pops, cost, back pops and push.
// ============================================================================
module chtsd_back #(
    parameter int MAX_ITEMS = 1024,
    parameter int LEN_W     = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [chtsd_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  chtsd_pkg::item_t                 q_item,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [chtsd_pkg::COST_W-1:0]     m_cost,
    output logic                             m_sat
);
    import chtsd_pkg::*;

    localparam int DEPTH  = MAX_ITEMS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W  = $clog2(MAX_ITEMS) + LEN_W + 1;
    localparam int LP_W   = LIMIT_W + 1;
    localparam int XW     = ((KEY_W > LP_W) ? KEY_W : LP_W) + 1;
    localparam int PW     = WORD_W + MUL_W;

    // Hull memories: x, stored cost and y = cost + x*x of each point.
    logic [KEY_W-1:0]  hx_mem [DEPTH];
    logic [WORD_W-1:0] hc_mem [DEPTH];
    logic [WORD_W-1:0] hy_mem [DEPTH];

    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              mem_we;
    logic [KEY_W-1:0]  wr_x;
    logic [WORD_W-1:0] wr_c, wr_y;
    logic [KEY_W-1:0]  rd_x_reg;
    logic [WORD_W-1:0] rd_c_reg, rd_y_reg;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [LEN_FIELD_W-1:0] len_reg, len_next;
    logic               restart_reg, restart_next;
    logic [XW-1:0]      s_reg, s_next, lp_reg, lp_next, kmag_reg, kmag_next;
    logic               kneg_reg, kneg_next;
    logic [XW-1:0]      px_reg, px_next, qx_reg, qx_next;
    logic [XW-1:0]      rx_reg, rx_next, lx_reg, lx_next;
    logic [WORD_W-1:0]  pc_reg, pc_next, qc_reg, qc_next;
    logic [WORD_W-1:0]  py_reg, py_next, qy_reg, qy_next;
    logic [WORD_W-1:0]  ry_reg, ry_next, ly_reg, ly_next;
    logic [WORD_W-1:0]  f_reg, f_next, ynew_reg, ynew_next, last_f_reg, last_f_next;
    logic               sat_reg, sat_next;
    logic [WORD_W-1:0]  prod_reg, prod_next;
    logic [WORD_W-1:0]  m1_reg, m1_next, m2_reg, m2_next;
    logic               n1_reg, n1_next, n2_reg, n2_next;
    logic [XW-1:0]      dx1_reg, dx1_next, dx2_reg, dx2_next;
    logic [WORD_W-1:0]  pp0_reg, pp0_next, pp1_reg, pp1_next;
    logic [WORD_W-1:0]  pp2_reg, pp2_next, pp3_reg, pp3_next;
    logic [PW-1:0]      p1_reg, p1_next, p2_reg, p2_next;
    logic               out_valid_reg, out_valid_next;
    logic [COST_W-1:0]  out_cost_reg, out_cost_next;
    logic               out_sat_reg, out_sat_next;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic               live_ge2, restart_eff, seq_full;
    logic               front_pop, back_pop, front_more, back_more, out_free;
    logic               dneg;
    logic [WORD_W-1:0]  dmag;
    logic [XW-1:0]      u_val, mag_val, s_calc;
    logic [WORD_W-1:0]  f_sum;

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_cost   = out_cost_reg;
    assign m_sat    = out_sat_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Shared decision terms.
    always_comb begin
        live_ge2    = (tail_reg - head_reg) >= IDX_W'(2);
        restart_eff = restart_reg || (head_reg >= tail_reg);
        seq_full    = !restart_eff && (count_reg >= CNT_W'(MAX_ITEMS));
        dneg        = qy_reg < py_reg;
        dmag        = dneg ? (py_reg - qy_reg) : (qy_reg - py_reg);
        front_pop   = $signed(dneg ? -{2'b00, dmag} : {2'b00, dmag})
                      <= $signed(kneg_reg ? -{2'b00, prod_reg} : {2'b00, prod_reg});
        back_pop    = $signed(n1_reg ? -{1'b0, p1_reg} : {1'b0, p1_reg})
                      >= $signed(n2_reg ? -{1'b0, p2_reg} : {1'b0, p2_reg});
        front_more  = (tail_reg - head_reg - IDX_W'(1)) >= IDX_W'(2);
        back_more   = (tail_reg - IDX_W'(1) - head_reg) >= IDX_W'(2);
        s_calc      = XW'(key_reg) + XW'(len_reg) + XW'(1);
        u_val       = px_reg + lp_reg;
        mag_val     = (s_reg >= u_val) ? (s_reg - u_val) : (u_val - s_reg);
        f_sum       = pc_reg + prod_reg;
    end

    // The one multiplier; its product is always registered by the caller.
    always_comb begin
        unique case (state_reg)
            ST_F_MUL: begin
                mul_a = MUL_W'(kmag_reg);
                mul_b = MUL_W'(qx_reg - px_reg);
            end
            ST_EV_MAG: begin
                mul_a = MUL_W'(mag_val);
                mul_b = MUL_W'(mag_val);
            end
            ST_EV_SQ: begin
                mul_a = MUL_W'(s_reg);
                mul_b = MUL_W'(s_reg);
            end
            ST_B_M0: begin
                mul_a = m1_reg[MUL_W-1:0];
                mul_b = MUL_W'(dx2_reg);
            end
            ST_B_M1: begin
                mul_a = m1_reg[WORD_W-1:MUL_W];
                mul_b = MUL_W'(dx2_reg);
            end
            ST_B_M2: begin
                mul_a = m2_reg[MUL_W-1:0];
                mul_b = MUL_W'(dx1_reg);
            end
            ST_B_M3: begin
                mul_a = m2_reg[WORD_W-1:MUL_W];
                mul_b = MUL_W'(dx1_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (q_valid) state_next = ST_START;
            ST_START:   state_next = seq_full ? ST_OUT : ST_KEY;
            ST_KEY:     state_next = ST_F_RDP;
            ST_F_RDP:   state_next = ST_F_LATP;
            ST_F_LATP:  state_next = live_ge2 ? ST_F_LATQ : ST_EV_MAG;
            ST_F_LATQ:  state_next = ST_F_MUL;
            ST_F_MUL:   state_next = ST_F_CMP;
            ST_F_CMP:   state_next = (front_pop && front_more) ? ST_F_LATQ : ST_EV_MAG;
            ST_EV_MAG:  state_next = ST_EV_COST;
            ST_EV_COST: state_next = ST_EV_SQ;
            ST_EV_SQ:   state_next = ST_EV_Y;
            ST_EV_Y:    state_next = ST_B_CHK;
            ST_B_CHK:   state_next = live_ge2 ? ST_B_LATR : ST_PUSH;
            ST_B_LATR:  state_next = ST_B_LATL;
            ST_B_LATL:  state_next = ST_B_M0;
            ST_B_M0:    state_next = ST_B_M1;
            ST_B_M1:    state_next = ST_B_M2;
            ST_B_M2:    state_next = ST_B_M3;
            ST_B_M3:    state_next = ST_B_SUM;
            ST_B_SUM:   state_next = ST_B_CMP;
            ST_B_CMP:   state_next = (back_pop && back_more) ? ST_B_LATL : ST_PUSH;
            ST_PUSH:    state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        len_next       = len_reg;
        restart_next   = restart_reg;
        s_next         = s_reg;
        lp_next        = lp_reg;
        kmag_next      = kmag_reg;
        kneg_next      = kneg_reg;
        px_next        = px_reg;
        qx_next        = qx_reg;
        rx_next        = rx_reg;
        lx_next        = lx_reg;
        pc_next        = pc_reg;
        qc_next        = qc_reg;
        py_next        = py_reg;
        qy_next        = qy_reg;
        ry_next        = ry_reg;
        ly_next        = ly_reg;
        f_next         = f_reg;
        ynew_next      = ynew_reg;
        last_f_next    = last_f_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        dx1_next       = dx1_reg;
        dx2_next       = dx2_reg;
        pp0_next       = pp0_reg;
        pp1_next       = pp1_reg;
        pp2_next       = pp2_reg;
        pp3_next       = pp3_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cost_next  = out_cost_reg;
        out_sat_next   = out_sat_reg;
        rd_addr        = ADDR_W'(head_reg);
        mem_we         = 1'b0;
        wr_addr        = ADDR_W'(tail_reg);
        wr_x           = s_reg[KEY_W-1:0];
        wr_c           = f_reg;
        wr_y           = ynew_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    len_next     = q_item.len;
                    restart_next = q_item.first;
                end
            end
            ST_START: begin
                if (restart_eff) begin
                    key_next   = '0;
                    count_next = '0;
                    head_next  = '0;
                    tail_next  = IDX_W'(1);
                    mem_we     = 1'b1;
                    wr_addr    = '0;
                    wr_x       = '0;
                    wr_c       = '0;
                    wr_y       = '0;
                end
                if (seq_full) begin
                    f_next   = last_f_reg;
                    sat_next = 1'b1;
                end
            end
            ST_KEY: begin
                s_next     = s_calc;
                count_next = count_reg + CNT_W'(1);
                lp_next    = XW'(limit_reg) + XW'(1);
                kneg_next  = s_calc < (XW'(limit_reg) + XW'(1));
                kmag_next  = (s_calc < (XW'(limit_reg) + XW'(1)))
                             ? XW'((XW'(limit_reg) + XW'(1) - s_calc) << 1)
                             : XW'((s_calc - XW'(limit_reg) - XW'(1)) << 1);
                sat_next   = 1'b0;
            end
            ST_F_RDP: begin
                rd_addr = ADDR_W'(head_reg);
            end
            ST_F_LATP: begin
                px_next = XW'(rd_x_reg);
                pc_next = rd_c_reg;
                py_next = rd_y_reg;
                rd_addr = ADDR_W'(head_reg + IDX_W'(1));
            end
            ST_F_LATQ: begin
                qx_next = XW'(rd_x_reg);
                qc_next = rd_c_reg;
                qy_next = rd_y_reg;
            end
            ST_F_MUL: begin
                prod_next = mul_p;
            end
            ST_F_CMP: begin
                if (front_pop) begin
                    head_next = head_reg + IDX_W'(1);
                    px_next   = qx_reg;
                    pc_next   = qc_reg;
                    py_next   = qy_reg;
                    rd_addr   = ADDR_W'(head_reg + IDX_W'(2));
                end
            end
            ST_EV_MAG: begin
                prod_next = mul_p;
            end
            ST_EV_COST: begin
                if (f_sum > COST_MAX) begin
                    f_next   = COST_MAX;
                    sat_next = 1'b1;
                end else begin
                    f_next = f_sum;
                end
            end
            ST_EV_SQ: begin
                prod_next = mul_p;
            end
            ST_EV_Y: begin
                ynew_next = f_reg + prod_reg;
            end
            ST_B_CHK: begin
                rd_addr = ADDR_W'(tail_reg - IDX_W'(1));
            end
            ST_B_LATR: begin
                rx_next  = XW'(rd_x_reg);
                ry_next  = rd_y_reg;
                n2_next  = ynew_reg < rd_y_reg;
                m2_next  = (ynew_reg < rd_y_reg) ? (rd_y_reg - ynew_reg)
                                                 : (ynew_reg - rd_y_reg);
                dx2_next = s_reg - XW'(rd_x_reg);
                rd_addr  = ADDR_W'(tail_reg - IDX_W'(2));
            end
            ST_B_LATL: begin
                lx_next  = XW'(rd_x_reg);
                ly_next  = rd_y_reg;
                n1_next  = ry_reg < rd_y_reg;
                m1_next  = (ry_reg < rd_y_reg) ? (rd_y_reg - ry_reg) : (ry_reg - rd_y_reg);
                dx1_next = rx_reg - XW'(rd_x_reg);
            end
            ST_B_M0: pp0_next = mul_p;
            ST_B_M1: pp1_next = mul_p;
            ST_B_M2: pp2_next = mul_p;
            ST_B_M3: pp3_next = mul_p;
            ST_B_SUM: begin
                p1_next = {pp1_reg, {MUL_W{1'b0}}} + PW'(pp0_reg);
                p2_next = {pp3_reg, {MUL_W{1'b0}}} + PW'(pp2_reg);
            end
            ST_B_CMP: begin
                if (back_pop) begin
                    tail_next = tail_reg - IDX_W'(1);
                    rx_next   = lx_reg;
                    ry_next   = ly_reg;
                    n2_next   = ynew_reg < ly_reg;
                    m2_next   = (ynew_reg < ly_reg) ? (ly_reg - ynew_reg)
                                                    : (ynew_reg - ly_reg);
                    dx2_next  = s_reg - lx_reg;
                    rd_addr   = ADDR_W'(tail_reg - IDX_W'(3));
                end
            end
            ST_PUSH: begin
                if (tail_reg <= IDX_W'(MAX_ITEMS)) begin
                    mem_we    = 1'b1;
                    tail_next = tail_reg + IDX_W'(1);
                end
                key_next    = s_reg[KEY_W-1:0];
                last_f_next = f_reg;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cost_next  = f_reg[COST_W-1:0];
                    out_sat_next   = sat_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            key_reg       <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        restart_reg  <= restart_next;
        s_reg        <= s_next;
        lp_reg       <= lp_next;
        kmag_reg     <= kmag_next;
        kneg_reg     <= kneg_next;
        px_reg       <= px_next;
        qx_reg       <= qx_next;
        rx_reg       <= rx_next;
        lx_reg       <= lx_next;
        pc_reg       <= pc_next;
        qc_reg       <= qc_next;
        py_reg       <= py_next;
        qy_reg       <= qy_next;
        ry_reg       <= ry_next;
        ly_reg       <= ly_next;
        f_reg        <= f_next;
        ynew_reg     <= ynew_next;
        last_f_reg   <= last_f_next;
        sat_reg      <= sat_next;
        prod_reg     <= prod_next;
        m1_reg       <= m1_next;
        m2_reg       <= m2_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        dx1_reg      <= dx1_next;
        dx2_reg      <= dx2_next;
        pp0_reg      <= pp0_next;
        pp1_reg      <= pp1_next;
        pp2_reg      <= pp2_next;
        pp3_reg      <= pp3_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        out_cost_reg <= out_cost_next;
        out_sat_reg  <= out_sat_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hx_mem[wr_addr] <= wr_x;
            hc_mem[wr_addr] <= wr_c;
            hy_mem[wr_addr] <= wr_y;
        end
        rd_x_reg <= hx_mem[rd_addr];
        rd_c_reg <= hc_mem[rd_addr];
        rd_y_reg <= hy_mem[rd_addr];
    end

    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("hull head passed the tail");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into the output register");

    a_front_pop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_F_CMP && front_pop) |=> (head_reg == $past(head_reg) + IDX_W'(1)))
        else $error("front pop did not advance the head by one");

endmodule

/* sv/convex_hull_trick_segment_dp_core.sv */
// ============================================================================
// convex_hull_trick_segment_dp_core
// Segmentation DP cost engine using the convex hull trick on a monotone queue.
// ============================================================================
// Steps: each item runs a key step, the front-of-hull tests, the cost
//   evaluation, the back-of-hull tests and the push before its result.
// Throughput: one item at a time; every point is pushed and popped at most
//   once, and the pace is set by the shared 32x32 multiplier and the single
//   read port of the hull memories.
// Reset: aresetn is synchronous, active low; it clears the queues, the hull
//   pointers and the limit register. Hull memories need no clearing pass.
module convex_hull_trick_segment_dp_core #(
    parameter int MAX_ITEMS = 1024,
    parameter int ITEM_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: line_limit, written whenever cfg_we is high.
    input  logic                          cfg_we,
    input  logic [chtsd_pkg::LIMIT_W-1:0] cfg_wdata,
    // Input item channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] item_length
    input  logic                          s_tuser,   // [0] first_item
    // Result item channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [61:0] best_cost, [63:62] zero
    output logic                          m_tuser    // [0] saturated
);
    import chtsd_pkg::*;

    // Only the low ITEM_BITS bits of the length field take part.
    localparam int LEN_W = (ITEM_BITS < LEN_FIELD_W) ? ITEM_BITS : LEN_FIELD_W;

    // The front side takes items and queues them; the back side runs the
    // hull and holds its result in an output register, so an item can be
    // accepted while an earlier result still waits on m_tready.
    logic              q_valid;
    logic              q_ready;
    item_t             q_item;
    logic [COST_W-1:0] cost;

    chtsd_front #(
        .LEN_W (LEN_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // The back side restarts the hull at the origin point when an item
    // carries first_item or arrives with no open sequence. After MAX_ITEMS
    // items the state stays put and the last cost repeats with saturated set.
    chtsd_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .LEN_W     (LEN_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_cost    (cost),
        .m_sat     (m_tuser)
    );

    assign m_tdata = {2'b00, cost};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the convex hull trick segmentation DP core. Item
// lengths and sequence starts are streamed in under several idling phases,
// the line limit is changed between phases, and every result item is checked
// against a cycle-free model of the monotone-queue hull kept in the bench.
// ============================================================================
module tb_top;
    import chtsd_pkg::*;

    localparam int MAXN     = 1024;
    localparam int WATCHDOG = 100000;

    typedef struct {
        logic [61:0] cost;
        logic        sat;
    } result_t;

    typedef struct {
        logic [15:0] len;
        logic        first;
        logic        check;     // typed-in expectation present
        logic [61:0] cost;
        logic        sat;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [25:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    convex_hull_trick_segment_dp_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Bench copy of the hull state and the limit register.
    logic [25:0]  limit_q;
    logic [63:0]  key_q;
    int unsigned  count_q;
    logic [63:0]  px [MAXN+1];
    logic [63:0]  pcost [MAXN+1];
    int unsigned  head_q, tail_q;

    result_t  cost_queue[$];
    int       errors;
    int       sender_idle_pct, receiver_stall_pct;
    int       quiet_cycles;

    // Signed-magnitude product compare: returns -1, 0 or 1 for a*b vs c*d.
    function automatic int cmp_prod(logic an, logic [63:0] am, logic [63:0] b,
                                    logic cn, logic [63:0] cm, logic [63:0] d);
        logic [127:0] p;
        logic [127:0] q;
        int mc;
        if (am == 0) an = 1'b0;
        if (cm == 0) cn = 1'b0;
        if (an != cn) return an ? -1 : 1;
        p = 128'(am) * 128'(b);
        q = 128'(cm) * 128'(d);
        mc = (p < q) ? -1 : (p > q) ? 1 : 0;
        return an ? -mc : mc;
    endfunction

    // Advances the hull by one item and returns the segmentation cost.
    function automatic result_t segment_cost(logic [15:0] len, logic first);
        result_t r;
        logic [63:0] lp, s, kmag, u, mag, f, ynew, dx, yp, yq, dmag;
        logic [63:0] yl, yr, dx1, dx2, m1, m2;
        logic kneg, dneg, n1, n2;
        if (first || head_q >= tail_q) begin
            key_q = 0; count_q = 0; px[0] = 0; pcost[0] = 0;
            head_q = 0; tail_q = 1;
        end
        if (count_q >= MAXN) begin
            r.cost = pcost[tail_q-1][61:0];
            r.sat  = 1'b1;
            return r;
        end
        r.sat = 1'b0;
        s = key_q + len + 1;
        count_q++;
        lp = limit_q + 1;
        kneg = s < lp;
        kmag = kneg ? 2 * (lp - s) : 2 * (s - lp);
        // Front pops: drop points whose slope to the next is at most k.
        while (tail_q - head_q >= 2) begin
            dx = px[head_q+1] - px[head_q];
            yp = pcost[head_q] + px[head_q] * px[head_q];
            yq = pcost[head_q+1] + px[head_q+1] * px[head_q+1];
            dneg = yq < yp;
            dmag = dneg ? yp - yq : yq - yp;
            if (cmp_prod(dneg, dmag, 1, kneg, kmag, dx) <= 0) head_q++;
            else break;
        end
        u = px[head_q] + lp;
        mag = s >= u ? s - u : u - s;
        f = pcost[head_q] + mag * mag;
        if (f > COST_MAX) begin
            f = COST_MAX;
            r.sat = 1'b1;
        end
        ynew = f + s * s;
        // Back pops keep the lower hull convex.
        while (tail_q - head_q >= 2) begin
            yl = pcost[tail_q-2] + px[tail_q-2] * px[tail_q-2];
            yr = pcost[tail_q-1] + px[tail_q-1] * px[tail_q-1];
            dx1 = px[tail_q-1] - px[tail_q-2];
            dx2 = s - px[tail_q-1];
            n1 = yr < yl;
            n2 = ynew < yr;
            m1 = n1 ? yl - yr : yr - yl;
            m2 = n2 ? yr - ynew : ynew - yr;
            if (cmp_prod(n1, m1, dx2, n2, m2, dx1) >= 0) tail_q--;
            else break;
        end
        if (tail_q <= MAXN) begin
            px[tail_q] = s; pcost[tail_q] = f; tail_q++;
        end
        key_q = s;
        r.cost = f[61:0];
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Sends one item; the expectation is queued at the accepting edge. The
    // valid line stays high after acceptance until the next call or drain
    // decides what follows, so it is never assigned twice in one time step.
    task automatic send_item(logic [15:0] len, logic first);
        result_t exp_r;
        while (($urandom % 100) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        exp_r = segment_cost(len, first);
        cost_queue.insert(cost_queue.size(), exp_r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (cost_queue.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_limit(logic [25:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_q = value;
    endtask

    // Receiver: random stalls, checks each result against the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cost_queue.size() == 0) begin
                    $error("unexpected result item cost=%0d", m_tdata[61:0]);
                    errors++;
                end else begin
                    want = cost_queue[0];
                    cost_queue.delete(0);
                    if (m_tdata[61:0] !== want.cost) begin
                        $error("best_cost expected %0d actual %0d", want.cost, m_tdata[61:0]);
                        errors++;
                    end
                    if (m_tdata[63:62] !== 2'b00) begin
                        $error("pad expected 0 actual %0d", m_tdata[63:62]);
                        errors++;
                    end
                    if (m_tuser !== want.sat) begin
                        $error("saturated expected %0d actual %0d", want.sat, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= (($urandom % 100) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    row_t rows[$];

    task automatic add_row(logic [15:0] len, logic first, logic check,
                           logic [61:0] cost, logic sat);
        row_t r;
        r.len = len; r.first = first; r.check = check; r.cost = cost; r.sat = sat;
        rows.insert(rows.size(), r);
    endtask

    initial begin
        result_t got;
        int      phase;
        int      run_len;
        errors = 0; quiet_cycles = 0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        limit_q = 0; key_q = 0; count_q = 0; head_q = 0; tail_q = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows. With limit 0 (Lp = 1) a lone first item of length 0
        // has s = 1 and cost 0; length 65535 gives (65536 - 1)^2.
        add_row(16'd0,     1'b0, 1'b1, 62'd0, 1'b0);   // no open sequence yet
        add_row(16'd0,     1'b1, 1'b1, 62'd0, 1'b0);
        add_row(16'hFFFF,  1'b1, 1'b1, 62'd4294836225, 1'b0);
        add_row(16'hFFFF,  1'b0, 1'b0, '0, 1'b0);
        add_row(16'h5555,  1'b0, 1'b0, '0, 1'b0);
        add_row(16'hAAAA,  1'b0, 1'b0, '0, 1'b0);
        add_row(16'd1,     1'b1, 1'b0, '0, 1'b0);
        add_row(16'd3,     1'b0, 1'b0, '0, 1'b0);
        add_row(16'd0,     1'b0, 1'b0, '0, 1'b0);
        add_row(16'd7,     1'b0, 1'b0, '0, 1'b0);
        foreach (rows[i]) begin
            send_item(rows[i].len, rows[i].first);
            if (rows[i].check) begin
                got = cost_queue[$];
                if (got.cost !== rows[i].cost || got.sat !== rows[i].sat) begin
                    $error("directed row %0d: model cost %0d sat %0d, table %0d %0d",
                           i, got.cost, got.sat, rows[i].cost, rows[i].sat);
                    errors++;
                end
            end
        end
        drain();

        // Limit at its top value; small limits favor many cuts.
        write_limit(26'h3FFFFFF);
        send_item(16'hFFFF, 1'b1);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd0, 1'b0);
        drain();

        // Sequence-full case: 1024 items, then more without a new start.
        write_limit(26'd100);
        send_item(16'd50, 1'b1);
        for (int i = 1; i < MAXN + 3; i++) send_item(16'($urandom_range(0, 200)), 1'b0);
        drain();

        // Random phases with several limits and idling mixes.
        for (phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
            endcase
            write_limit(26'($urandom_range(0, 70000)));
            for (int n = 0; n < 16; ) begin
                run_len = $urandom_range(1, 12);
                for (int j = 0; j < run_len; j++) begin
                    send_item(($urandom % 4 == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 3000)),
                              (j == 0) ? 1'b1 : ($urandom % 50 == 0));
                end
                n += run_len;
            end
            drain();
        end
        sender_idle_pct = 0; receiver_stall_pct = 0;
        write_limit(26'd0);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
